[design/prds_pkg.sv]
// Package: types, constants and codes shared by the particle step core.
`default_nettype none
package prds_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_START_X   = 3'd0;
  localparam logic [2:0] REG_START_Y   = 3'd1;
  localparam logic [2:0] REG_RADIUS    = 3'd2;
  localparam logic [2:0] REG_STRENGTH  = 3'd3;
  localparam logic [2:0] REG_DAMPING   = 3'd4;

  localparam logic [30:0] RADIUS_RST   = 31'd6553600;
  localparam logic [30:0] STRENGTH_RST = 31'd65536;
  localparam logic [15:0] DAMPING_RST  = 16'd62259;

  // Action codes
  localparam logic [1:0] ACT_FORCE = 2'd0;
  localparam logic [1:0] ACT_REPEL = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] x_value;
    logic signed [31:0] y_value;
  } req_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
  } rsp_t;

  // Datapath operations commanded by the controller
  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_FORCE, OP_DIFF, OP_SQ, OP_CHECK, OP_SQRT, OP_PCT,
    OP_UDIV, OP_MUL1, OP_MUL2, OP_ACCUM, OP_VEL, OP_POS, OP_DAMP
  } op_e;

  typedef struct packed {
    op_e  op;
    logic axis;   // 0 x, 1 y
  } cmd_t;

  typedef struct packed {
    logic skip;   // repel adds nothing
    logic busy;   // iterative unit still working
  } stat_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOAD, ST_DISPATCH, ST_FORCE, ST_DIFF, ST_SQ, ST_CHECK, ST_SQRT,
    ST_PCT, ST_UDIV, ST_MUL1, ST_MUL2, ST_ACCUM, ST_VEL, ST_POS, ST_DAMP
  } state_e;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sd2147483647) return 32'sh7fffffff;
    else if (v < -34'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction

endpackage
`default_nettype wire

[design/prds_ctrl.sv]
// Controller: sequences the datapath operations for one request.
`default_nettype none
module prds_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire logic [1:0]     action_i,
  input  wire prds_pkg::stat_t stat_i,
  input  wire logic           out_free_i,
  output prds_pkg::cmd_t      cmd_o,
  output logic                idle_o,
  output logic                done_o
);
  import prds_pkg::*;

  state_e     state_q, state_d;
  logic       axis_q, axis_d;
  logic [1:0] action_q, action_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      axis_q   <= 1'b0;
      action_q <= ACT_FORCE;
    end else begin
      state_q  <= state_d;
      axis_q   <= axis_d;
      action_q <= action_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d  = state_q;
    axis_d   = axis_q;
    action_d = action_q;
    cmd_o    = '{op: OP_NONE, axis: axis_q};
    idle_o   = 1'b0;
    done_o   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        idle_o = 1'b1;
        if (start_i) begin
          cmd_o.op = OP_LOAD;
          action_d = action_i;
          state_d  = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        axis_d = 1'b0;
        case (action_q)
          ACT_FORCE: state_d = ST_FORCE;
          ACT_REPEL: state_d = ST_DIFF;
          ACT_TICK:  state_d = ST_VEL;
          default:   state_d = ST_LOAD;
        endcase
      end
      ST_FORCE: begin
        cmd_o.op = OP_FORCE;
        state_d  = ST_LOAD;
      end
      ST_DIFF: begin
        cmd_o.op = OP_DIFF;
        state_d  = ST_SQ;
      end
      ST_SQ: begin
        cmd_o.op = OP_SQ;
        if (axis_q) begin
          axis_d  = 1'b0;
          state_d = ST_CHECK;
        end else begin
          axis_d = 1'b1;
        end
      end
      ST_CHECK: begin
        cmd_o.op = OP_CHECK;
        state_d  = ST_SQRT;
      end
      ST_SQRT: begin
        if (stat_i.skip) begin
          state_d = ST_LOAD;
        end else begin
          cmd_o.op = OP_SQRT;
          if (!stat_i.busy) state_d = ST_PCT;
        end
      end
      ST_PCT: begin
        cmd_o.op = OP_PCT;
        if (!stat_i.busy) state_d = ST_UDIV;
      end
      ST_UDIV: begin
        cmd_o.op = OP_UDIV;
        if (!stat_i.busy) state_d = ST_MUL1;
      end
      ST_MUL1: begin
        cmd_o.op = OP_MUL1;
        state_d  = ST_MUL2;
      end
      ST_MUL2: begin
        cmd_o.op = OP_MUL2;
        state_d  = ST_ACCUM;
      end
      ST_ACCUM: begin
        cmd_o.op = OP_ACCUM;
        if (axis_q) begin
          state_d = ST_LOAD;
        end else begin
          axis_d  = 1'b1;
          state_d = ST_UDIV;
        end
      end
      ST_VEL: begin
        cmd_o.op = OP_VEL;
        state_d  = ST_POS;
      end
      ST_POS: begin
        cmd_o.op = OP_POS;
        state_d  = ST_DAMP;
      end
      ST_DAMP: begin
        cmd_o.op = OP_DAMP;
        if (axis_q) begin
          state_d = ST_LOAD;
        end else begin
          axis_d = 1'b1;
        end
      end
      ST_LOAD: begin
        // hand the position to the output register
        if (out_free_i) begin
          done_o  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

[design/prds_dp.sv]
// Datapath: particle state, config registers, and the repulsion arithmetic.
`default_nettype none
module prds_dp (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire prds_pkg::cmd_t cmd_i,
  input  wire prds_pkg::req_t req_i,
  input  wire logic           cfg_we_i,
  input  wire logic [2:0]     cfg_idx_i,
  input  wire logic [31:0]    cfg_data_i,
  output logic [31:0]         cfg_rdata_o,
  output prds_pkg::stat_t     stat_o,
  output prds_pkg::rsp_t      pos_o
);
  import prds_pkg::*;

  logic signed [31:0] start_x_q, start_y_q;
  logic [30:0]        radius_q, strength_q;
  logic [15:0]        damp_q;
  logic signed [31:0] px_q, py_q, vx_q, vy_q, axc_q, ayc_q;
  req_t               req_q;
  logic [32:0]        adx_q, ady_q;     // magnitudes of the offsets
  logic               sgx_q, sgy_q;
  logic [63:0]        d2_q, r2_q;
  logic               skip_q;
  // shared iterative unit: remainder, working value, result, count
  logic [64:0]        rem_q;
  logic [63:0]        wk_q;
  logic [63:0]        res_q;
  logic [6:0]         cnt_q;
  logic               run_q;
  logic [31:0]        len_q;
  logic [16:0]        pct_q;
  logic [16:0]        u_q;
  logic [33:0]        m_q;
  logic [63:0]        f_q;

  // Config register read
  always_comb begin
    case (cfg_idx_i)
      REG_START_X:  cfg_rdata_o = start_x_q;
      REG_START_Y:  cfg_rdata_o = start_y_q;
      REG_RADIUS:   cfg_rdata_o = {1'b0, radius_q};
      REG_STRENGTH: cfg_rdata_o = {1'b0, strength_q};
      REG_DAMPING:  cfg_rdata_o = {16'd0, damp_q};
      default:      cfg_rdata_o = '0;
    endcase
  end

  assign pos_o  = '{pos_x: px_q, pos_y: py_q};
  // busy until the unit has run and holds its last count for one cycle
  assign stat_o = '{skip: skip_q, busy: run_q || (cnt_q == 7'd0)};

  // Operand selection per axis
  logic signed [31:0] vel_sel;
  logic [32:0]        ad_sel;
  logic               sg_sel;
  always_comb begin
    vel_sel = cmd_i.axis ? vy_q : vx_q;
    ad_sel  = cmd_i.axis ? ady_q : adx_q;
    sg_sel  = cmd_i.axis ? sgy_q : sgx_q;
  end

  logic signed [33:0] dx_w, dy_w;
  assign dx_w = 34'(px_q) - 34'(req_q.x_value);
  assign dy_w = 34'(py_q) - 34'(req_q.y_value);

  logic [64:0] sq_trial;
  assign sq_trial = {1'b0, rem_q[63:0]} - {1'b0, res_q | wk_q};
  logic [64:0] dv_shift;
  assign dv_shift = {rem_q[63:0], 1'b0};
  logic [31:0] damp_mag;
  logic [47:0] damp_prod;
  assign damp_mag  = vel_sel[31] ? 32'(-vel_sel) : 32'(vel_sel);
  assign damp_prod = damp_mag * damp_q;

  // Particle state (reset loads start position)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_x_q  <= '0;
      start_y_q  <= '0;
      radius_q   <= RADIUS_RST;
      strength_q <= STRENGTH_RST;
      damp_q     <= DAMPING_RST;
      px_q <= '0; py_q <= '0; vx_q <= '0; vy_q <= '0;
      axc_q <= '0; ayc_q <= '0;
      run_q <= 1'b0;
      cnt_q <= '0;
      skip_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_START_X:  begin start_x_q <= cfg_data_i; px_q <= cfg_data_i; end
          REG_START_Y:  begin start_y_q <= cfg_data_i; py_q <= cfg_data_i; end
          REG_RADIUS:   radius_q   <= cfg_data_i[30:0];
          REG_STRENGTH: strength_q <= cfg_data_i[30:0];
          REG_DAMPING:  damp_q     <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      case (cmd_i.op)
        OP_FORCE: begin
          axc_q <= sat32(34'(axc_q) + 34'(req_q.x_value));
          ayc_q <= sat32(34'(ayc_q) + 34'(req_q.y_value));
        end
        OP_CHECK: begin
          skip_q <= (adx_q >= 33'(radius_q)) || (ady_q >= 33'(radius_q)) ||
                    (d2_q >= r2_q) || (d2_q == 64'd0);
          run_q <= 1'b0;
          cnt_q <= '0;
        end
        OP_SQRT, OP_PCT, OP_UDIV: begin
          if (!run_q && cnt_q == 7'd0) begin
            run_q <= 1'b1;
            cnt_q <= (cmd_i.op == OP_SQRT) ? 7'd32 :
                     (cmd_i.op == OP_PCT) ? 7'd16 : 7'd17;
          end else if (run_q) begin
            // last step keeps the count so the unit reads as finished
            if (cnt_q == 7'd1) run_q <= 1'b0;
            else cnt_q <= cnt_q - 7'd1;
          end else begin
            cnt_q <= '0;
          end
        end
        OP_ACCUM: begin
          if (cmd_i.axis) ayc_q <= sat32(34'(ayc_q) + (sg_sel ? -34'(f_q[31:0]) :
                                                         34'(f_q[31:0])));
          else axc_q <= sat32(34'(axc_q) + (sg_sel ? -34'(f_q[31:0]) :
                                             34'(f_q[31:0])));
          cnt_q <= '0;
        end
        OP_VEL: begin
          vx_q  <= sat32(34'(vx_q) + 34'(axc_q));
          vy_q  <= sat32(34'(vy_q) + 34'(ayc_q));
          axc_q <= '0;
          ayc_q <= '0;
        end
        OP_POS: begin
          px_q <= sat32(34'(px_q) + 34'(vx_q));
          py_q <= sat32(34'(py_q) + 34'(vy_q));
        end
        OP_DAMP: begin
          if (cmd_i.axis) vy_q <= vel_sel[31] ? -$signed(32'(damp_prod[47:16]))
                                              : $signed(32'(damp_prod[47:16]));
          else vx_q <= vel_sel[31] ? -$signed(32'(damp_prod[47:16]))
                                   : $signed(32'(damp_prod[47:16]));
        end
        default: ;
      endcase
    end
  end

  // Payload registers of the repulsion math
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: req_q <= req_i;
      OP_DIFF: begin
        adx_q <= dx_w[33] ? 33'(-dx_w) : 33'(dx_w);
        ady_q <= dy_w[33] ? 33'(-dy_w) : 33'(dy_w);
        sgx_q <= dx_w[33];
        sgy_q <= dy_w[33];
      end
      OP_SQ: begin
        // first pass: dx^2 and r^2; second pass: add dy^2
        if (!cmd_i.axis) begin
          d2_q <= adx_q[31:0] * adx_q[31:0];
          r2_q <= radius_q * radius_q;
        end else begin
          d2_q <= d2_q + ady_q[31:0] * ady_q[31:0];
        end
      end
      OP_SQRT: begin
        if (!run_q && cnt_q == 7'd0) begin
          rem_q <= {1'b0, d2_q};
          wk_q  <= 64'h4000_0000_0000_0000;
          res_q <= '0;
        end else if (run_q) begin
          if (!sq_trial[64]) begin
            rem_q <= sq_trial;
            res_q <= (res_q >> 1) + wk_q;
          end else begin
            res_q <= res_q >> 1;
          end
          wk_q <= wk_q >> 2;
          if (cnt_q == 7'd1) len_q <= 32'((res_q >> 1) + (sq_trial[64] ? 64'd0 : wk_q));
        end
      end
      OP_PCT: begin
        if (!run_q && cnt_q == 7'd0) begin
          rem_q <= {1'b0, r2_q - d2_q};
          res_q <= '0;
        end else if (run_q) begin
          if (dv_shift >= {1'b0, r2_q}) begin
            rem_q <= dv_shift - {1'b0, r2_q};
            res_q <= {res_q[62:0], 1'b1};
          end else begin
            rem_q <= dv_shift;
            res_q <= {res_q[62:0], 1'b0};
          end
        end else begin
          pct_q <= 17'(res_q[15:0]);
        end
      end
      OP_UDIV: begin
        // |d| * 2^16 / len, 17 quotient bits (|d| <= len)
        if (!run_q && cnt_q == 7'd0) begin
          rem_q <= {32'd0, ad_sel[31:0], 1'b0} >> 1;
          res_q <= '0;
        end else if (run_q) begin
          if ((cnt_q == 7'd17 ? {1'b0, rem_q[63:0]} : dv_shift) >= {33'd0, len_q}) begin
            rem_q <= (cnt_q == 7'd17 ? {1'b0, rem_q[63:0]} : dv_shift) - {33'd0, len_q};
            res_q <= {res_q[62:0], 1'b1};
          end else begin
            rem_q <= (cnt_q == 7'd17 ? {1'b0, rem_q[63:0]} : dv_shift);
            res_q <= {res_q[62:0], 1'b0};
          end
        end else begin
          u_q <= res_q[16:0];
        end
      end
      OP_MUL1: m_q <= 34'((u_q * pct_q) >> 16);
      OP_MUL2: f_q <= {16'd0, 48'(m_q[16:0] * strength_q) >> 16};
      default: ;
    endcase
  end
endmodule
`default_nettype wire

[design/particle_repulsion_damped_step_core.sv]
// Top level: handshakes, APB config port, controller and datapath.
// Repel runs a square root, a ratio and two divides on the shared iterative unit, and skips
// them when the point is out of reach; force, tick and unused actions need none of them.
// One request at a time; the next is taken the cycle after the result loads;
// a waiting unaccepted result stalls the load.
// Reset: position from start registers (zero), velocity, acceleration zero, config defaults.
`default_nettype none
module particle_repulsion_damped_step_core (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire prds_pkg::req_t in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output prds_pkg::rsp_t      out_data_o,
  input  wire logic           psel,
  input  wire logic           penable,
  input  wire logic           pwrite,
  input  wire logic [4:0]     paddr,
  input  wire logic [31:0]    pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import prds_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  idle, done, start;
  rsp_t  pos;
  logic  out_valid_q;
  rsp_t  out_data_q;

  assign pready     = 1'b1;
  assign in_ready_o = idle;
  assign start      = in_valid_i && idle;

  prds_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .action_i(in_data_i.action),
    .stat_i(stat), .out_free_i(!out_valid_q || out_ready_i),
    .cmd_o(cmd), .idle_o(idle), .done_o(done)
  );

  prds_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .req_i(in_data_i),
    .cfg_we_i(psel && penable && pwrite), .cfg_idx_i(paddr[4:2]),
    .cfg_data_i(pwdata), .cfg_rdata_o(prdata), .stat_o(stat), .pos_o(pos)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (done) out_valid_q <= 1'b1;
    else if (out_ready_i) out_valid_q <= 1'b0;
  end
  always_ff @(posedge clk_i) if (done) out_data_q <= pos;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_done_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> (!out_valid_q || out_ready_i)) else $error("result overwritten");
  a_done_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> out_valid_q) else $error("result lost");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> !in_ready_o) else $error("second request taken while busy");
endmodule
`default_nettype wire

[test/particle_repulsion_damped_step_core_tb.sv]
// Testbench for the particle step core: directed and random requests checked against a predictor.
`timescale 1ns / 100ps
`default_nettype none

// Scoreboard: particle state predictor and queue of expected positions.
class particle_sb;
  logic signed [31:0] pos_x, pos_y, vel_x, vel_y, acc_x, acc_y;
  logic signed [31:0] start_x, start_y;
  logic [30:0] radius, strength;
  logic [15:0] damping;
  prds_pkg::rsp_t pos_q[$];
  int errors;

  function new();
    start_x = 0;
    start_y = 0;
    radius = prds_pkg::RADIUS_RST;
    strength = prds_pkg::STRENGTH_RST;
    damping = prds_pkg::DAMPING_RST;
    pos_x = 0;
    pos_y = 0;
    vel_x = 0;
    vel_y = 0;
    acc_x = 0;
    acc_y = 0;
    errors = 0;
  endfunction

  function logic signed [31:0] clamp(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function logic signed [31:0] damp_vel(input logic signed [31:0] v);
    longint mag;
    longint r;
    mag = (v < 0) ? -longint'(v) : longint'(v);
    r = (mag * longint'(damping)) >>> 16;
    return 32'((v < 0) ? -r : r);
  endfunction

  function longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function longint push_axis(input longint d, input longint unsigned len,
                             input longint unsigned pct);
    longint unsigned mag, u, m, f;
    mag = (d < 0) ? -d : d;
    u = (mag << 16) / len;
    m = (u * pct) >> 16;
    f = (m * longint'(strength)) >> 16;
    return (d < 0) ? -longint'(f) : longint'(f);
  endfunction

  function void repel(input longint px, input longint py);
    longint dx, dy;
    longint unsigned ax, ay, d2, r2, len, pct, num;
    dx = longint'(pos_x) - px;
    dy = longint'(pos_y) - py;
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    if (ax >= radius || ay >= radius) return;
    d2 = ax * ax + ay * ay;
    r2 = longint'(radius) * longint'(radius);
    if (d2 >= r2 || d2 == 0) return;
    len = int_sqrt(d2);
    // long division of (r2 - d2) << 16 by r2, avoiding overflow
    num = r2 - d2;
    pct = 0;
    for (int i = 0; i < 16; i++) begin
      num <<= 1;
      pct <<= 1;
      if (num >= r2) begin
        num -= r2;
        pct |= 1;
      end
    end
    acc_x = clamp(longint'(acc_x) + push_axis(dx, len, pct));
    acc_y = clamp(longint'(acc_y) + push_axis(dy, len, pct));
  endfunction

  function void write_reg(input logic [2:0] idx, input logic [31:0] val);
    case (idx)
      prds_pkg::REG_START_X: begin
        start_x = val;
        pos_x = val;
      end
      prds_pkg::REG_START_Y: begin
        start_y = val;
        pos_y = val;
      end
      prds_pkg::REG_RADIUS:   radius = val[30:0];
      prds_pkg::REG_STRENGTH: strength = val[30:0];
      prds_pkg::REG_DAMPING:  damping = val[15:0];
      default: ;
    endcase
  endfunction

  // Note an accepted request and queue the position it yields.
  function void note_request(input prds_pkg::req_t r);
    prds_pkg::rsp_t p;
    case (r.action)
      prds_pkg::ACT_FORCE: begin
        acc_x = clamp(longint'(acc_x) + longint'(r.x_value));
        acc_y = clamp(longint'(acc_y) + longint'(r.y_value));
      end
      prds_pkg::ACT_REPEL: repel(longint'(r.x_value), longint'(r.y_value));
      prds_pkg::ACT_TICK: begin
        vel_x = clamp(longint'(vel_x) + longint'(acc_x));
        vel_y = clamp(longint'(vel_y) + longint'(acc_y));
        pos_x = clamp(longint'(pos_x) + longint'(vel_x));
        pos_y = clamp(longint'(pos_y) + longint'(vel_y));
        acc_x = 0;
        acc_y = 0;
        vel_x = damp_vel(vel_x);
        vel_y = damp_vel(vel_y);
      end
      default: ;
    endcase
    p.pos_x = pos_x;
    p.pos_y = pos_y;
    pos_q.push_back(p);
  endfunction

  // Compare a returned position with the oldest expectation.
  function void check_result(input prds_pkg::rsp_t got);
    prds_pkg::rsp_t exp_p;
    if (pos_q.size() == 0) begin
      $error("unexpected result pos_x=%0d pos_y=%0d", got.pos_x, got.pos_y);
      errors++;
      return;
    end
    exp_p = pos_q.pop_front();
    if (got.pos_x !== exp_p.pos_x) begin
      $error("pos_x expected %0d actual %0d", exp_p.pos_x, got.pos_x);
      errors++;
    end
    if (got.pos_y !== exp_p.pos_y) begin
      $error("pos_y expected %0d actual %0d", exp_p.pos_y, got.pos_y);
      errors++;
    end
  endfunction
endclass

module particle_repulsion_damped_step_core_tb;
  import prds_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  req_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  rsp_t out_data_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // Register settings for the first four random phases
  logic [31:0] rad_set[4] = '{32'd0, 32'd6553600, 32'h7fffffff, 32'd1310720};
  logic [31:0] str_set[4] = '{32'd0, 32'd65536, 32'h7fffffff, 32'd327680};
  logic [15:0] dmp_set[4] = '{16'd0, 16'hffff, 16'd62259, 16'd32768};

  particle_sb sb;
  bit calm;       // no idling in the last part
  bit sink_on;

  particle_repulsion_damped_step_core dut (.*);

  always #4 clk_i = ~clk_i;

  // Result side: random stall bursts, check on each accepted result.
  initial begin
    int gap;
    while (!sink_on) @(posedge clk_i);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        gap = $urandom_range(1, 19);
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) sb.check_result(out_data_o);
    end
  end

  task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    sb.write_reg(idx, val);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic send_request(input req_t r);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      gap = $urandom_range(1, 19);
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= r;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_request(r);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pos_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 32'h000fffff);
      3: return -$urandom_range(0, 32'h000fffff);
      default: return $urandom;
    endcase
  endfunction

  // Random request; most repel requests land near the particle so repulsion actually acts.
  function automatic req_t rand_request();
    req_t r;
    int k;
    k = $urandom_range(0, 19);
    r.x_value = rand_word();
    r.y_value = rand_word();
    if (k < 6) begin
      r.action = ACT_FORCE;
      r.x_value = $signed($urandom_range(0, 32'h0003ffff)) - 32'sh00020000;
      r.y_value = $signed($urandom_range(0, 32'h0003ffff)) - 32'sh00020000;
      if (k == 0) begin
        r.x_value = rand_word();
        r.y_value = rand_word();
      end
    end else if (k < 13) begin
      r.action = ACT_REPEL;
      if (k < 12) begin
        r.x_value = sb.pos_x + ($signed($urandom_range(0, 32'h00c00000)) - 32'sh00600000);
        r.y_value = sb.pos_y + ($signed($urandom_range(0, 32'h00c00000)) - 32'sh00600000);
      end
    end else if (k < 19) begin
      r.action = ACT_TICK;
    end else begin
      r.action = 2'd3;
    end
    return r;
  endfunction

  initial begin
    req_t r;
    sb = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    sink_on = 1'b1;

    // Directed: extremes, each action, saturation, zero distance, outside radius.
    r = '{ACT_FORCE, 32'sh7fffffff, 32'sh80000000};
    send_request(r);
    send_request(r);
    r = '{ACT_TICK, 0, 0};
    send_request(r);
    send_request(r);
    r = '{ACT_FORCE, 32'sh80000000, 32'sh7fffffff};
    send_request(r);
    send_request(r);
    send_request(r);
    r = '{ACT_TICK, 0, 0};
    send_request(r);
    r = '{2'd3, 32'sh12345678, -32'sh1};
    send_request(r);
    drain();
    apb_write(REG_START_X, 32'd0);
    apb_write(REG_START_Y, 32'd0);
    r = '{ACT_REPEL, 0, 0};
    send_request(r);
    r = '{ACT_REPEL, 32'sh00010000, 32'sh00020000};
    send_request(r);
    r = '{ACT_REPEL, -32'sh00630000, 32'sh0};
    send_request(r);
    r = '{ACT_REPEL, 32'sh00640000, 32'sh0};
    send_request(r);
    r = '{ACT_REPEL, 32'sh7fffffff, 32'sh80000000};
    send_request(r);
    r = '{ACT_TICK, 0, 0};
    send_request(r);
    send_request(r);
    drain();

    // Random phases across register settings.
    for (int ph = 0; ph < 6; ph++) begin
      apb_write(REG_START_X, (ph == 1) ? 32'h7fffffff : (ph == 2) ? 32'h80000000 :
                $urandom_range(0, 32'h01ffffff) - 32'h00ffffff);
      apb_write(REG_START_Y, (ph == 1) ? 32'h80000000 : (ph == 2) ? 32'h7fffffff :
                $urandom_range(0, 32'h01ffffff) - 32'h00ffffff);
      apb_write(REG_RADIUS, (ph < 4) ? rad_set[ph] : $urandom);
      apb_write(REG_STRENGTH, (ph < 4) ? str_set[ph] : $urandom);
      apb_write(REG_DAMPING, (ph < 4) ? dmp_set[ph] : $urandom);
      if (ph == 5) calm = 1'b1;
      for (int i = 0; i < 120; i++) send_request(rand_request());
      drain();
    end

    if (sb.errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end
endmodule

`default_nettype wire

[filelist.f]
design/prds_pkg.sv
design/prds_ctrl.sv
design/prds_dp.sv
design/particle_repulsion_damped_step_core.sv
test/particle_repulsion_damped_step_core_tb.sv
